FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mcpf_pkg.sv
// Package: constants, opcodes and helpers of the motor command packet framer.
`timescale 1ns / 1ps
package mcpf_pkg;

	localparam int CMD_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int VOLT_W    = 13;
	localparam int FRAME_MAX = 9;
	localparam int CNT_W     = $clog2(FRAME_MAX + 1);

	// Command codes
	localparam logic [CMD_W-1:0] CMD_SPEED = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BAUD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MIN_V = 2'd2;
	localparam logic [CMD_W-1:0] CMD_MAX_V = 2'd3;

	// Protocol opcodes and the bauding byte
	localparam logic [BYTE_W-1:0] OP_M1_FWD = 8'd0;
	localparam logic [BYTE_W-1:0] OP_M1_REV = 8'd1;
	localparam logic [BYTE_W-1:0] OP_MIN_V  = 8'd2;
	localparam logic [BYTE_W-1:0] OP_MAX_V  = 8'd3;
	localparam logic [BYTE_W-1:0] OP_M2_FWD = 8'd4;
	localparam logic [BYTE_W-1:0] OP_M2_REV = 8'd5;
	localparam logic [BYTE_W-1:0] BAUD_BYTE = 8'hAA;

	localparam logic [BYTE_W-1:0] DEV_ADDR_RESET = 8'd128;
	localparam logic [BYTE_W-1:0] MAG_MAX        = 8'd127;
	localparam logic [BYTE_W-1:0] SPEED_MIN      = 8'h80;
	localparam logic [BYTE_W-1:0] DATA_SAT       = 8'd255;

	// Voltage scaling: 6 V floor, 20 cV per step; max scale 512/10000
	localparam logic [VOLT_W-1:0] MIN_V_FLOOR = 13'd600;
	localparam logic [VOLT_W-1:0] MAX_V_SAT   = 13'd5000;
	localparam logic [11:0]       RECIP_5     = 12'd3277;   // 2^14 / 5, rounded up
	localparam logic [17:0]       RECIP_625   = 18'd214749; // 2^27 / 625, rounded up

	// Register map
	localparam int          PADDR_W       = 2;
	localparam int          PDATA_W       = 32;
	localparam logic [PADDR_W-1:0] ADDR_DEV_ADDR = 2'd0;

	typedef logic [BYTE_W-1:0] byte_t;

	// Packet checksum: low seven bits of address + opcode + data
	function automatic byte_t checksum(input byte_t addr, input byte_t op, input byte_t data);
		byte_t sum;
		sum = addr + op + data;
		return sum & 8'h7F;
	endfunction

	// Speed magnitude clamped to 127
	function automatic byte_t speed_mag(input byte_t spd);
		byte_t mag;
		if (!spd[BYTE_W-1]) begin
			mag = spd;
		end else if (spd == SPEED_MIN) begin
			mag = MAG_MAX;
		end else begin
			mag = 8'd0 - spd;
		end
		return mag;
	endfunction

endpackage

FILE: rtl/motor_command_packet_framer_top.sv
// Top level: turns one motor command into the byte stream of a two-motor driver packet protocol.
`timescale 1ns / 1ps
// Usage
//   s_* channel takes one command per beat; m_* channel gives one byte per beat,
//   with m_tlast on the final byte of each command.
//   A speed command gives 9 bytes (bauding byte, left packet, right packet), bauding
//   only gives 1 byte, a voltage command gives one 4-byte packet.
//   The first byte is on m_tdata in the cycle after the command beat.
//   The output gives one byte per cycle while the receiver does not stall; the frame
//   shift register holding the bytes sets this rate.
//   The next command is taken in the same cycle in which the last byte of the current
//   one is taken, so commands follow without a gap.
//   When the receiver stalls, the current byte and frame hold and s_tready stays low
//   until the final byte goes. Reset clears the byte count (no output), both stored
//   speeds to 0 and the device address register to 128. The user must write the
//   address through the APB port only while idle; it is not enforced.
module motor_command_packet_framer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mcpf_pkg::PADDR_W-1:0]    paddr,
	input  logic [mcpf_pkg::PDATA_W-1:0]    pwdata,
	output logic [mcpf_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready,
	// Command input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [7:0] left_speed_cmd, [15:8] right_speed_cmd, [16] left_forward,
	// [17] right_forward, [30:18] voltage_cv, [31] zero
	input  logic [31:0]                     s_tdata,
	// [1:0] cmd
	input  logic [mcpf_pkg::CMD_W-1:0]      s_tuser,
	// Byte output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] tx_byte, [15:8] left_now, [23:16] right_now
	output logic [23:0]                     m_tdata,
	output logic                            m_tlast
);
	import mcpf_pkg::*;

	logic [CMD_W-1:0]  in_cmd;
	byte_t             in_left;
	byte_t             in_right;
	logic              in_left_fwd;
	logic              in_right_fwd;
	logic [VOLT_W-1:0] in_cv;

	byte_t             dev_addr_q;
	byte_t             left_q;
	byte_t             right_q;
	byte_t             frame_q [FRAME_MAX];
	logic [CNT_W-1:0]  rem_q;

	byte_t             frame_d [FRAME_MAX];
	logic [CNT_W-1:0]  len_d;
	byte_t             left_d;
	byte_t             right_d;
	byte_t             op_l;
	byte_t             op_r;
	byte_t             mag_l;
	byte_t             mag_r;
	logic [VOLT_W-1:0] min_x;
	logic [22:0]       min_prod;
	logic [8:0]        min_q;
	logic [30:0]       max_prod;
	logic [8:0]        max_q;
	byte_t             vop;
	byte_t             vdata;

	logic              cfg_wr;
	logic              in_fire;
	logic              out_fire;

	// Unpack the command beat
	assign in_cmd       = s_tuser;
	assign in_left      = s_tdata[7:0];
	assign in_right     = s_tdata[15:8];
	assign in_left_fwd  = s_tdata[16];
	assign in_right_fwd = s_tdata[17];
	assign in_cv        = s_tdata[30:18];

	// Configuration register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_DEV_ADDR);
	assign prdata = (paddr == ADDR_DEV_ADDR) ? {{(PDATA_W-BYTE_W){1'b0}}, dev_addr_q}
	                                         : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RESET;
		end else if (cfg_wr) begin
			dev_addr_q <= pwdata[BYTE_W-1:0];
		end
	end

	// Handshakes: take a command when the frame is empty or its final byte leaves
	assign m_tvalid = (rem_q != '0);
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (rem_q == '0) || ((rem_q == CNT_W'(1)) && m_tready);
	assign in_fire  = s_tvalid && s_tready;

	// Apply direction flags (negate with 8-bit wrap)
	always_comb begin
		left_d  = in_left_fwd  ? in_left  : 8'd0 - in_left;
		right_d = in_right_fwd ? in_right : 8'd0 - in_right;
		op_l    = left_d[BYTE_W-1]  ? OP_M2_REV : OP_M2_FWD;
		op_r    = right_d[BYTE_W-1] ? OP_M1_REV : OP_M1_FWD;
		mag_l   = speed_mag(left_d);
		mag_r   = speed_mag(right_d);
	end

	// Minimum voltage: (max(cv, 600) - 600) / 20 as (x >> 2) * recip(5)
	always_comb begin
		min_x    = (in_cv < MIN_V_FLOOR) ? '0 : in_cv - MIN_V_FLOOR;
		min_prod = 23'(min_x[VOLT_W-1:2]) * 23'(RECIP_5);
		min_q    = min_prod[22:14];
	end

	// Maximum voltage: cv * 32 / 625 via reciprocal, saturate from 50 V up
	always_comb begin
		max_prod = 31'(in_cv) * 31'(RECIP_625);
		max_q    = max_prod[30:22];
	end

	// Voltage packet opcode and data byte
	always_comb begin
		if (in_cmd == CMD_MIN_V) begin
			vop   = OP_MIN_V;
			vdata = (min_q > 9'(DATA_SAT)) ? DATA_SAT : min_q[BYTE_W-1:0];
		end else begin
			vop   = OP_MAX_V;
			vdata = (in_cv >= MAX_V_SAT || max_q > 9'(DATA_SAT)) ? DATA_SAT
			                                                      : max_q[BYTE_W-1:0];
		end
	end

	// Build the frame for the incoming command
	always_comb begin
		for (int i = 0; i < FRAME_MAX; i++) begin
			frame_d[i] = '0;
		end
		unique case (in_cmd)
			CMD_SPEED: begin
				len_d      = CNT_W'(9);
				frame_d[0] = BAUD_BYTE;
				frame_d[1] = dev_addr_q;
				frame_d[2] = op_l;
				frame_d[3] = mag_l;
				frame_d[4] = checksum(dev_addr_q, op_l, mag_l);
				frame_d[5] = dev_addr_q;
				frame_d[6] = op_r;
				frame_d[7] = mag_r;
				frame_d[8] = checksum(dev_addr_q, op_r, mag_r);
			end
			CMD_BAUD: begin
				len_d      = CNT_W'(1);
				frame_d[0] = BAUD_BYTE;
			end
			CMD_MIN_V, CMD_MAX_V: begin
				len_d      = CNT_W'(4);
				frame_d[0] = dev_addr_q;
				frame_d[1] = vop;
				frame_d[2] = vdata;
				frame_d[3] = checksum(dev_addr_q, vop, vdata);
			end
			default: begin
				len_d = '0;
			end
		endcase
	end

	// Frame byte count and stored speeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			if (in_fire) begin
				rem_q <= len_d;
				if (in_cmd == CMD_SPEED) begin
					left_q  <= left_d;
					right_q <= right_d;
				end
			end else if (out_fire) begin
				rem_q <= rem_q - CNT_W'(1);
			end
		end
	end

	// Frame shift register: load on a command, advance on each output beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			frame_q <= frame_d;
		end else if (out_fire) begin
			for (int i = 0; i < FRAME_MAX - 1; i++) begin
				frame_q[i] <= frame_q[i+1];
			end
		end
	end

	assign m_tdata = {right_q, left_q, frame_q[0]};
	assign m_tlast = (rem_q == CNT_W'(1));

endmodule

FILE: rtl/mcpf_chk.sv
// Checker: port-level assertions on the framer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mcpf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// Stalled output holds
	`AST_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "output dropped while stalled")
	`AST_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

	// A command is taken only when no frame is pending past this beat
	`AST_IMP(a_in_gap, clk, arst_n, s_tvalid && s_tready, !m_tvalid || (m_tlast && m_tready), "command taken mid-frame")

	// An accepted command shows its first byte next cycle
	`AST_NXT(a_in_to_out, clk, arst_n, s_tvalid && s_tready, m_tvalid, "no byte after command")

	// A frame continues until its last byte
	`AST_NXT(a_frame_cont, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid, "frame cut short")

endmodule

bind motor_command_packet_framer_top mcpf_chk u_mcpf_chk (.*);
